### design/x86ls_pkg.sv
// Shared types and constants for the x86 subset length scanner.
package x86ls_pkg;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        reads_memory_operand;
    logic [15:0] function_length;
  } rsp_t;

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_AFTER_PREFIX,
    PH_MODRM,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    OC_BAD,
    OC_RET,
    OC_ONE,
    OC_SKIP,
    OC_MOVRM
  } op_class_t;

  typedef struct packed {
    op_class_t  cls;
    logic [2:0] skip;
  } class_t;

  localparam logic [2:0] ST_INSIDE = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_RET    = 3'd2;
  localparam logic [2:0] ST_BAD    = 3'd3;
  localparam logic [2:0] ST_NORET  = 3'd4;

  localparam logic [7:0] OP_PREFIX   = 8'h66;
  localparam logic [7:0] MASK_ROW    = 8'hf0;
  localparam logic [7:0] MASK_REG    = 8'hf8;
  localparam logic [7:0] OP_INCDEC   = 8'h40;
  localparam logic [7:0] OP_MOV_IMM8 = 8'hb0;
  localparam logic [7:0] OP_MOV_IMMW = 8'hb8;
  localparam logic [7:0] OP_ADD      = 8'h03;
  localparam logic [7:0] OP_XCHG     = 8'h86;
  localparam logic [7:0] OP_ALU_IMM8 = 8'h83;
  localparam logic [7:0] OP_IMUL_W   = 8'h69;
  localparam logic [7:0] OP_IMUL_B   = 8'h6b;
  localparam logic [7:0] OP_MOV_RM8  = 8'h8a;
  localparam logic [7:0] OP_MOV_RMW  = 8'h8b;
  localparam logic [7:0] OP_STOS8    = 8'haa;
  localparam logic [7:0] OP_STOSW    = 8'hab;
  localparam logic [7:0] OP_RET      = 8'hc3;

  localparam logic [1:0]  MOD_DISP8  = 2'd1;
  localparam logic [1:0]  MOD_REG    = 2'd3;
  localparam logic [15:0] LEN_MAX    = 16'hffff;

endpackage

### design/x86ls_classify.sv
// Opcode classifier: instruction class and count of trailing operand bytes.
module x86ls_classify
  import x86ls_pkg::*;
(
  input  logic [7:0] op,
  input  logic       short_operand,
  output class_t     cls
);

  logic [2:0] wide;

  assign wide = short_operand ? 3'd2 : 3'd4;

  always_comb begin
    cls.cls  = OC_BAD;
    cls.skip = 3'd0;
    priority if ((op & MASK_ROW) == OP_INCDEC) begin
      cls.cls = OC_ONE;
    end else if ((op & MASK_REG) == OP_MOV_IMM8) begin
      cls.cls  = OC_SKIP;
      cls.skip = 3'd1;
    end else if ((op & MASK_REG) == OP_MOV_IMMW) begin
      cls.cls  = OC_SKIP;
      cls.skip = wide;
    end else if (op == OP_ADD || op == OP_XCHG) begin
      cls.cls  = OC_SKIP;
      cls.skip = 3'd1;
    end else if (op == OP_ALU_IMM8 || op == OP_IMUL_B) begin
      cls.cls  = OC_SKIP;
      cls.skip = 3'd2;
    end else if (op == OP_IMUL_W) begin
      cls.cls  = OC_SKIP;
      cls.skip = wide + 3'd1;
    end else if (op == OP_MOV_RM8 || op == OP_MOV_RMW) begin
      cls.cls = OC_MOVRM;
    end else if (op == OP_STOS8 || op == OP_STOSW) begin
      cls.cls = OC_ONE;
    end else if (op == OP_RET) begin
      cls.cls = OC_RET;
    end
  end

endmodule

### design/x86ls_core.sv
// Scan state registers and per-byte next-state and result logic.
module x86ls_core
  import x86ls_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t req,
  output rsp_t rsp
);

  phase_t      scan_phase, scan_phase_next;
  logic [2:0]  bytes_to_skip, bytes_to_skip_next;
  logic        short_operand, short_operand_next;
  logic        memory_read_seen, memory_read_seen_next;
  logic [15:0] byte_count, byte_count_next;
  logic [2:0]  status;
  logic [2:0]  skip_left;
  logic [1:0]  mod_bits;
  logic        restart;
  class_t      op_cls;

  x86ls_classify u_classify (
    .op            (req.code_byte),
    .short_operand (short_operand),
    .cls           (op_cls)
  );

  assign mod_bits  = req.code_byte[7:6];
  assign skip_left = (bytes_to_skip != 3'd0) ? bytes_to_skip - 3'd1 : 3'd0;

  always_comb begin
    scan_phase_next       = scan_phase;
    bytes_to_skip_next    = bytes_to_skip;
    short_operand_next    = short_operand;
    memory_read_seen_next = memory_read_seen;
    byte_count_next       = (byte_count != LEN_MAX) ? byte_count + 16'd1 : byte_count;
    status                = ST_INSIDE;

    unique case (scan_phase)
      PH_OPCODE, PH_AFTER_PREFIX: begin
        if (scan_phase == PH_OPCODE && req.code_byte == OP_PREFIX) begin
          short_operand_next = 1'b1;
          scan_phase_next    = PH_AFTER_PREFIX;
        end else begin
          unique case (op_cls.cls)
            OC_BAD: status = ST_BAD;
            OC_RET: status = ST_RET;
            OC_ONE: begin
              status             = ST_DONE;
              scan_phase_next    = PH_OPCODE;
              short_operand_next = 1'b0;
            end
            OC_MOVRM: scan_phase_next = PH_MODRM;
            OC_SKIP: begin
              bytes_to_skip_next = op_cls.skip;
              scan_phase_next    = PH_SKIP;
            end
            default: status = ST_BAD;
          endcase
        end
      end
      PH_MODRM: begin
        if (mod_bits != MOD_REG) memory_read_seen_next = 1'b1;
        if (mod_bits == MOD_DISP8) begin
          bytes_to_skip_next = 3'd1;
          scan_phase_next    = PH_SKIP;
        end else begin
          status             = ST_DONE;
          scan_phase_next    = PH_OPCODE;
          short_operand_next = 1'b0;
        end
      end
      PH_SKIP: begin
        bytes_to_skip_next = skip_left;
        if (skip_left == 3'd0) begin
          status             = ST_DONE;
          scan_phase_next    = PH_OPCODE;
          short_operand_next = 1'b0;
        end
      end
      default: scan_phase_next = PH_OPCODE;
    endcase

    if (req.last_byte && status != ST_RET && status != ST_BAD) status = ST_NORET;
  end

  assign restart = (status == ST_RET) || (status == ST_BAD) || (status == ST_NORET);

  assign rsp.status               = status;
  assign rsp.reads_memory_operand = memory_read_seen_next;
  assign rsp.function_length      = byte_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase       <= PH_OPCODE;
      bytes_to_skip    <= 3'd0;
      short_operand    <= 1'b0;
      memory_read_seen <= 1'b0;
      byte_count       <= 16'd0;
    end else if (step) begin
      if (restart) begin
        scan_phase       <= PH_OPCODE;
        bytes_to_skip    <= 3'd0;
        short_operand    <= 1'b0;
        memory_read_seen <= 1'b0;
        byte_count       <= 16'd0;
      end else begin
        scan_phase       <= scan_phase_next;
        bytes_to_skip    <= bytes_to_skip_next;
        short_operand    <= short_operand_next;
        memory_read_seen <= memory_read_seen_next;
        byte_count       <= byte_count_next;
      end
    end
  end

endmodule

### design/x86_subset_length_scanner_unit.sv
// Top level of the x86 subset length scanner: request register, scan core, result register.
//
// Usage:
//   Requests carry one code byte and a last-byte flag on req_valid/req_ready/req.
//   Each request produces exactly one result on rsp_valid/rsp_ready/rsp with the
//   status of that byte, the sticky memory-operand flag and the running function
//   length (saturating at 65535).
//   Path: an accepted request waits in the request register, and its result is
//   then held in the result register.
//   Throughput: one byte per cycle while rsp_ready stays high; the scan state is
//   updated as each byte moves from the request register into the result
//   register, so consecutive bytes follow back to back.
//   Stall: while rsp_ready is low the result holds; one more request can still
//   be taken into the request register, then req_ready drops.
//   Reset (rst, synchronous): both registers empty, scan state back to the start
//   of a function. A ret, an unhandled opcode or the last byte also restarts it.
module x86_subset_length_scanner_unit
  import x86ls_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  req_t req_q;
  logic req_q_valid;
  logic advance;
  rsp_t core_rsp;

  assign advance   = req_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_q_valid || advance;

  x86ls_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (req_q),
    .rsp  (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_ready) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) req_q <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) rsp <= core_rsp;
  end

endmodule

### design/x86ls_checker.sv
// Port-level checks for the x86 subset length scanner, bound to the top level.
module x86ls_checker
  import x86ls_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ST_NORET)
    else $error("status code out of range");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.function_length != 16'd0)
    else $error("function length zero on a result");

  a_first_byte_mem: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.function_length == 16'd1 |-> !rsp.reads_memory_operand)
    else $error("memory operand flagged on first byte of a function");

endmodule

bind x86_subset_length_scanner_unit x86ls_checker u_x86ls_checker (.*);
